// ===== rtl/vtae_pkg.sv =====
package vtae_pkg;

  typedef enum logic [1:0] {
    OP_COORD = 2'd0,
    OP_PEN   = 2'd1,
    OP_TEXT  = 2'd2
  } op_t;

  localparam int NUM_SLOTS = 5;

  localparam int SLOT_HIGH_Y = 0;
  localparam int SLOT_EXTRA  = 1;
  localparam int SLOT_LOW_Y  = 2;
  localparam int SLOT_HIGH_X = 3;
  localparam int SLOT_LOW_X  = 4;

  localparam logic [11:0] X_LIMIT = 12'd4095;
  localparam logic [11:0] Y_LIMIT = 12'd3071;

  localparam logic [7:0] TAG_HIGH   = 8'h20;
  localparam logic [7:0] TAG_LOW_Y  = 8'h60;
  localparam logic [7:0] TAG_LOW_X  = 8'h40;
  localparam logic [7:0] CTRL_PEN   = 8'd29;
  localparam logic [7:0] CTRL_TEXT  = 8'd31;
  localparam logic [7:0] PREV_RESET = 8'hFF;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    slot_mask_t                send;
    logic [NUM_SLOTS-1:0][7:0] bytes;
  } entry_t;

endpackage

// ===== rtl/vtae_front.sv =====
module vtae_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     op,
  input  logic [15:0]    x_coord,
  input  logic [15:0]    y_coord,
  input  logic           queue_full,
  output logic           push,
  output vtae_pkg::entry_t push_entry
);

  logic [7:0]  prev_high_y;
  logic [7:0]  prev_high_x;
  logic [7:0]  prev_low_y;
  logic [7:0]  prev_extra_bits;
  logic [11:0] x_sat;
  logic [11:0] y_sat;
  logic [4:0]  high_y;
  logic [4:0]  low_y;
  logic [4:0]  high_x;
  logic [4:0]  low_x;
  logic [4:0]  extra;
  logic        ch_hy;
  logic        ch_eb;
  logic        ch_ly;
  logic        ch_hx;
  logic        accept;
  logic        is_coord;
  logic        is_valid_op;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign x_sat = (x_coord > {4'd0, vtae_pkg::X_LIMIT}) ? vtae_pkg::X_LIMIT : x_coord[11:0];
  assign y_sat = (y_coord > {4'd0, vtae_pkg::Y_LIMIT}) ? vtae_pkg::Y_LIMIT : y_coord[11:0];

  assign high_y = y_sat[11:7];
  assign low_y  = y_sat[6:2];
  assign high_x = x_sat[11:7];
  assign low_x  = x_sat[6:2];
  assign extra  = {1'b0, y_sat[1:0], x_sat[1:0]};

  assign ch_hy = {3'd0, high_y} != prev_high_y;
  assign ch_eb = {3'd0, extra}  != prev_extra_bits;
  assign ch_ly = {3'd0, low_y}  != prev_low_y;
  assign ch_hx = {3'd0, high_x} != prev_high_x;

  always_comb begin
    push_entry  = '0;
    is_coord    = 1'b0;
    is_valid_op = 1'b1;
    unique case (vtae_pkg::op_t'(op))
      vtae_pkg::OP_COORD: begin
        is_coord = 1'b1;
        push_entry.send[vtae_pkg::SLOT_HIGH_Y]  = ch_hy;
        push_entry.send[vtae_pkg::SLOT_EXTRA]   = ch_eb;
        push_entry.send[vtae_pkg::SLOT_LOW_Y]   = ch_eb || ch_ly || ch_hx;
        push_entry.send[vtae_pkg::SLOT_HIGH_X]  = ch_hx;
        push_entry.send[vtae_pkg::SLOT_LOW_X]   = 1'b1;
        push_entry.bytes[vtae_pkg::SLOT_HIGH_Y] = {3'd0, high_y} | vtae_pkg::TAG_HIGH;
        push_entry.bytes[vtae_pkg::SLOT_EXTRA]  = {3'd0, extra}  | vtae_pkg::TAG_LOW_Y;
        push_entry.bytes[vtae_pkg::SLOT_LOW_Y]  = {3'd0, low_y}  | vtae_pkg::TAG_LOW_Y;
        push_entry.bytes[vtae_pkg::SLOT_HIGH_X] = {3'd0, high_x} | vtae_pkg::TAG_HIGH;
        push_entry.bytes[vtae_pkg::SLOT_LOW_X]  = {3'd0, low_x}  | vtae_pkg::TAG_LOW_X;
      end
      vtae_pkg::OP_PEN: begin
        push_entry.send[vtae_pkg::SLOT_LOW_X]  = 1'b1;
        push_entry.bytes[vtae_pkg::SLOT_LOW_X] = vtae_pkg::CTRL_PEN;
      end
      vtae_pkg::OP_TEXT: begin
        push_entry.send[vtae_pkg::SLOT_LOW_X]  = 1'b1;
        push_entry.bytes[vtae_pkg::SLOT_LOW_X] = vtae_pkg::CTRL_TEXT;
      end
      default: begin
        is_valid_op = 1'b0;
      end
    endcase
  end

  assign push = accept && is_valid_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_high_y     <= vtae_pkg::PREV_RESET;
      prev_high_x     <= vtae_pkg::PREV_RESET;
      prev_low_y      <= vtae_pkg::PREV_RESET;
      prev_extra_bits <= vtae_pkg::PREV_RESET;
    end else if (accept && is_coord) begin
      prev_high_y     <= {3'd0, high_y};
      prev_high_x     <= {3'd0, high_x};
      prev_low_y      <= {3'd0, low_y};
      prev_extra_bits <= {3'd0, extra};
    end
  end

endmodule

// ===== rtl/vtae_queue.sv =====
module vtae_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vtae_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output vtae_pkg::entry_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtae_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vtae_back.sv =====
module vtae_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             queue_not_empty,
  input  vtae_pkg::entry_t queue_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_byte
);

  logic                       busy;
  logic                       busy_next;
  vtae_pkg::slot_mask_t       mask;
  vtae_pkg::slot_mask_t       mask_next;
  logic [vtae_pkg::NUM_SLOTS-1:0][7:0] bytes;
  vtae_pkg::slot_mask_t       sel;
  logic [7:0]                 sel_byte;
  logic                       sel_last;
  logic                       emit;

  always_comb begin
    sel      = '0;
    sel_byte = bytes[vtae_pkg::SLOT_LOW_X];
    priority if (mask[vtae_pkg::SLOT_HIGH_Y]) begin
      sel[vtae_pkg::SLOT_HIGH_Y] = 1'b1;
      sel_byte = bytes[vtae_pkg::SLOT_HIGH_Y];
    end else if (mask[vtae_pkg::SLOT_EXTRA]) begin
      sel[vtae_pkg::SLOT_EXTRA] = 1'b1;
      sel_byte = bytes[vtae_pkg::SLOT_EXTRA];
    end else if (mask[vtae_pkg::SLOT_LOW_Y]) begin
      sel[vtae_pkg::SLOT_LOW_Y] = 1'b1;
      sel_byte = bytes[vtae_pkg::SLOT_LOW_Y];
    end else if (mask[vtae_pkg::SLOT_HIGH_X]) begin
      sel[vtae_pkg::SLOT_HIGH_X] = 1'b1;
      sel_byte = bytes[vtae_pkg::SLOT_HIGH_X];
    end else begin
      sel[vtae_pkg::SLOT_LOW_X] = 1'b1;
    end
  end

  assign sel_last = (mask & ~sel) == '0;
  assign emit     = busy && (!out_valid || out_ready);
  assign pop      = queue_not_empty && (!busy || (emit && sel_last));

  always_comb begin
    busy_next = busy;
    mask_next = mask;
    if (emit) begin
      mask_next = mask & ~sel;
      if (sel_last) begin
        busy_next = 1'b0;
      end
    end
    if (pop) begin
      busy_next = 1'b1;
      mask_next = queue_entry.send;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes <= queue_entry.bytes;
    end
    if (emit) begin
      out_byte  <= sel_byte;
      last_byte <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      mask <= mask_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/vector_terminal_address_encoder_top.sv =====
// Channel  Handshake             Word
// input    in_valid / in_ready   op, x_coord, y_coord
// output   out_valid / out_ready out_byte, last_byte
//
// A coordinate word yields one to five output words, and a pen or text word yields one.
// The back end sends one output word per cycle while the output is not stalled.
// Input words are accepted every cycle while the queue between front and back has room.
// Reset clears the queue and the output valid flag, and sets the stored fields to 255.
// A stalled output holds its word; the queue keeps accepting until it fills.
module vector_terminal_address_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] x_coord,
  input  logic [15:0] y_coord,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_not_empty;
  vtae_pkg::entry_t push_entry;
  vtae_pkg::entry_t pop_entry;

  vtae_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  vtae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .pop_entry  (pop_entry)
  );

  vtae_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .queue_entry     (pop_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_byte       (last_byte)
  );

endmodule

// ===== rtl/vtae_checker.sv =====
module vtae_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last_byte
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("Stalled output word changed.");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output word shown right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("Waiting input word was withdrawn.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |-> out_byte[7:5] == 3'b001 || out_byte[7:5] == 3'b011)
    else $error("Non-final word lacks a high or low-y tag.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> out_byte[7:5] == 3'b010 || out_byte == vtae_pkg::CTRL_PEN ||
                               out_byte == vtae_pkg::CTRL_TEXT)
    else $error("Final word is neither low-x nor a control byte.");

endmodule

bind vector_terminal_address_encoder_top vtae_checker u_vtae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last_byte (last_byte)
);

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 370;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
  } plot_cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } link_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [15:0] x_coord = '0;
  logic [15:0] y_coord = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  plot_cmd_t  cmd_queue[$];
  link_word_t pending_bytes[$];

  logic [7:0] prev_high_y = vtae_pkg::PREV_RESET;
  logic [7:0] prev_high_x = vtae_pkg::PREV_RESET;
  logic [7:0] prev_low_y = vtae_pkg::PREV_RESET;
  logic [7:0] prev_extra_bits = vtae_pkg::PREV_RESET;

  bit word_taken = 1'b0;
  int total_cmds = 0;
  int accepted_count = 0;
  int coord_count = 0;
  int mode_count = 0;
  int ignored_count = 0;
  int full_coord_count = 0;
  int bytes_checked = 0;
  int errors = 0;

  logic [15:0] gen_x = '0;
  logic [15:0] gen_y = '0;

  int burst_left = 1;
  int gap_left = 0;
  int ready_cycle = 0;
  int stall_left = 0;

  vector_terminal_address_encoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  always #5 clk = ~clk;

  function automatic link_word_t link_word(input logic [7:0] value, input logic last);
    link_word_t w;
    w.value = value;
    w.last = last;
    return w;
  endfunction

  function automatic logic [15:0] clamp_near(input logic [15:0] base, input int hi);
    int v;
    v = int'(base) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v[15:0];
  endfunction

  task automatic encode_plot_cmd(input plot_cmd_t c);
    logic [11:0] cx, cy;
    logic [7:0]  hy, ly, hx, lx, eb;
    logic        ch_hy, ch_eb, ch_ly, ch_hx;
    int          n;
    n = 1;
    case (c.op)
      vtae_pkg::OP_PEN: pending_bytes.push_back(link_word(vtae_pkg::CTRL_PEN, 1'b1));
      vtae_pkg::OP_TEXT: pending_bytes.push_back(link_word(vtae_pkg::CTRL_TEXT, 1'b1));
      vtae_pkg::OP_COORD: begin
        cx = (c.x > vtae_pkg::X_LIMIT) ? vtae_pkg::X_LIMIT : c.x[11:0];
        cy = (c.y > vtae_pkg::Y_LIMIT) ? vtae_pkg::Y_LIMIT : c.y[11:0];
        hy = {3'b000, cy[11:7]};
        ly = {3'b000, cy[6:2]};
        hx = {3'b000, cx[11:7]};
        lx = {3'b000, cx[6:2]};
        eb = {4'b0000, cy[1:0], cx[1:0]};
        ch_hy = hy != prev_high_y;
        ch_eb = eb != prev_extra_bits;
        ch_ly = ly != prev_low_y;
        ch_hx = hx != prev_high_x;
        if (ch_hy) begin
          pending_bytes.push_back(link_word(hy | vtae_pkg::TAG_HIGH, 1'b0));
          n++;
        end
        if (ch_eb) begin
          pending_bytes.push_back(link_word(eb | vtae_pkg::TAG_LOW_Y, 1'b0));
          n++;
        end
        if (ch_eb || ch_ly || ch_hx) begin
          pending_bytes.push_back(link_word(ly | vtae_pkg::TAG_LOW_Y, 1'b0));
          n++;
        end
        if (ch_hx) begin
          pending_bytes.push_back(link_word(hx | vtae_pkg::TAG_HIGH, 1'b0));
          n++;
        end
        pending_bytes.push_back(link_word(lx | vtae_pkg::TAG_LOW_X, 1'b1));
        if (n == vtae_pkg::NUM_SLOTS) full_coord_count++;
        prev_high_y = hy;
        prev_high_x = hx;
        prev_low_y = ly;
        prev_extra_bits = eb;
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [1:0] c_op, input logic [15:0] x, input logic [15:0] y);
    plot_cmd_t c;
    c.op = c_op;
    c.x = x;
    c.y = y;
    cmd_queue.push_back(c);
    total_cmds++;
    case (c_op)
      vtae_pkg::OP_COORD: begin
        coord_count++;
        gen_x = (x > vtae_pkg::X_LIMIT) ? 16'(vtae_pkg::X_LIMIT) : x;
        gen_y = (y > vtae_pkg::Y_LIMIT) ? 16'(vtae_pkg::Y_LIMIT) : y;
      end
      vtae_pkg::OP_PEN, vtae_pkg::OP_TEXT: mode_count++;
      default: ignored_count++;
    endcase
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(negedge clk) begin : driver
    logic      next_valid;
    plot_cmd_t next_cmd;
    next_valid = in_valid;
    next_cmd.op = op;
    next_cmd.x = x_coord;
    next_cmd.y = y_coord;
    if (!rst && (!in_valid || word_taken)) begin
      if (gap_left > 0) begin
        next_valid = 1'b0;
        gap_left--;
      end else if (cmd_queue.size() > 0) begin
        next_cmd = cmd_queue.pop_front();
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        next_valid = 1'b0;
      end
    end
    in_valid <= next_valid;
    op <= next_cmd.op;
    x_coord <= next_cmd.x;
    y_coord <= next_cmd.y;
  end

  // Receiver: cycles through always-ready, light, heavy and long-stall phases.
  always @(negedge clk) begin : receiver
    logic ready;
    ready = 1'b1;
    ready_cycle++;
    case ((ready_cycle / 97) % 4)
      0: ready = 1'b1;
      1: ready = $urandom_range(0, 3) != 0;
      2: ready = $urandom_range(0, 2) == 0;
      default: begin
        if (stall_left > 0) begin
          ready = 1'b0;
          stall_left--;
        end else begin
          ready = 1'b1;
          stall_left = $urandom_range(0, 10);
        end
      end
    endcase
    out_ready <= ready;
  end

  always @(posedge clk) begin : monitor
    link_word_t want;
    plot_cmd_t  got;
    word_taken = !rst && in_valid && in_ready;
    if (word_taken) begin
      got.op = op;
      got.x = x_coord;
      got.y = y_coord;
      encode_plot_cmd(got);
      accepted_count++;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: no word expected, got %02h (last_byte %0b)", out_byte, last_byte);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, out_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, last_byte);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int          counted;
    int          r;
    logic [15:0] nx, ny;

    add_cmd(vtae_pkg::OP_PEN, 16'd0, 16'd0);
    add_cmd(vtae_pkg::OP_COORD, 16'd0, 16'd0);
    add_cmd(vtae_pkg::OP_COORD, 16'd0, 16'd0);
    add_cmd(vtae_pkg::OP_TEXT, 16'd0, 16'd0);
    add_cmd(vtae_pkg::OP_COORD, 16'd4095, 16'd3071);
    add_cmd(vtae_pkg::OP_COORD, 16'hFFFF, 16'hFFFF);
    add_cmd(vtae_pkg::OP_COORD, 16'd4096, 16'd3072);
    add_cmd(vtae_pkg::OP_COORD, 16'd4095, 16'd2943);
    add_cmd(vtae_pkg::OP_COORD, 16'd4094, 16'd2943);
    add_cmd(vtae_pkg::OP_COORD, 16'd4094, 16'd2939);
    add_cmd(vtae_pkg::OP_COORD, 16'd3966, 16'd2939);
    add_cmd(vtae_pkg::OP_COORD, 16'd3962, 16'd2939);
    add_cmd(OP_UNUSED, 16'h1234, 16'h5678);
    add_cmd(vtae_pkg::OP_COORD, 16'hAAAA, 16'h5555);
    add_cmd(vtae_pkg::OP_COORD, 16'h0AAA, 16'h0555);
    add_cmd(vtae_pkg::OP_COORD, 16'h0555, 16'h0AAA);
    add_cmd(vtae_pkg::OP_PEN, 16'hFFFF, 16'hFFFF);
    add_cmd(vtae_pkg::OP_TEXT, 16'h5555, 16'hAAAA);
    add_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    add_cmd(vtae_pkg::OP_COORD, 16'd0, 16'd3071);
    add_cmd(vtae_pkg::OP_COORD, 16'd4095, 16'd0);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        add_cmd(vtae_pkg::OP_PEN, 16'($urandom), 16'($urandom));
        counted++;
      end else if (r < 13) begin
        add_cmd(vtae_pkg::OP_TEXT, 16'($urandom), 16'($urandom));
        counted++;
      end else if (r < 18) begin
        add_cmd(OP_UNUSED, 16'($urandom), 16'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        nx = gen_x;
        ny = gen_y;
        if (r < 40) begin
          nx = clamp_near(gen_x, 4095);
          ny = clamp_near(gen_y, 3071);
        end else if (r < 55) begin
          case ($urandom_range(0, 4))
            0: ny[11:7] = 5'($urandom);
            1: begin
              nx[1:0] = 2'($urandom);
              ny[1:0] = 2'($urandom);
            end
            2: ny[6:2] = 5'($urandom);
            3: nx[11:7] = 5'($urandom);
            default: nx[6:2] = 5'($urandom);
          endcase
        end else if (r < 80) begin
          nx = 16'($urandom_range(0, 4095));
          ny = 16'($urandom_range(0, 3071));
        end else begin
          nx = 16'($urandom);
          ny = 16'($urandom);
        end
        add_cmd(vtae_pkg::OP_COORD, nx, ny);
        counted++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_cmds) @(posedge clk);
    for (int i = 0; i < 20000 && pending_bytes.size() != 0; i++) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("out_byte: %0d expected words never arrived", pending_bytes.size());
      errors++;
    end
    repeat (20) @(posedge clk);

    $display("Run covered %0d coordinate words (%0d with all five bytes), %0d mode words",
             coord_count, full_coord_count, mode_count);
    $display("and %0d unused-op words; %0d output words were checked.",
             ignored_count, bytes_checked);
    if (errors == 0) begin
      $display("** vector_terminal_address_encoder_top: PASSED **");
    end else begin
      $display("** vector_terminal_address_encoder_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d of %0d input words accepted.", accepted_count, total_cmds);
    $display("** vector_terminal_address_encoder_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vtae_pkg.sv
rtl/vtae_front.sv
rtl/vtae_queue.sv
rtl/vtae_back.sv
rtl/vector_terminal_address_encoder_top.sv
rtl/vtae_checker.sv
verif/testbench.sv
